// ===== rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  // product, final value, scaled numerator and quotient widths
  localparam int PW = 2 * DATA_WIDTH;
  localparam int VW = 2 * DATA_WIDTH + 2;
  localparam int MW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int QW = DATA_WIDTH;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_CONJ = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CONJ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         div_by_zero;
  } rsp_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } item_t;

endpackage

// ===== rtl/cau_front.sv =====
module cau_front (
  input  cau_pkg::req_t  req,
  output cau_pkg::item_t item
);
  import cau_pkg::*;

  op_t op;

  always_comb begin
    case (req.cmd)
      CMD_ADD:  op = OP_ADD;
      CMD_SUB:  op = OP_SUB;
      CMD_MUL:  op = OP_MUL;
      CMD_DIV:  op = OP_DIV;
      CMD_CONJ: op = OP_CONJ;
      default:  op = OP_NONE;
    endcase
  end

  assign item.op   = op;
  assign item.a_re = req.a_re;
  assign item.a_im = req.a_im;
  assign item.b_re = req.b_re;
  assign item.b_im = req.b_im;

endmodule

// ===== rtl/cau_queue.sv =====
module cau_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cau_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output cau_pkg::item_t rdata
);
  import cau_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t          mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== rtl/cau_back.sv =====
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  cau_pkg::item_t item,
  output logic           item_take,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cau_pkg::rsp_t  rsp
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = PW + QW + 1;
  localparam int NS = QW + 3;

  typedef struct packed {
    op_t                 op;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic [PW-1:0]        d_r;
    logic [PW-1:0]        d_i;
    logic signed [W+1:0]  s_re;
    logic signed [W+1:0]  s_im;
  } prod_t;

  typedef struct packed {
    op_t                 op;
    logic signed [VW-1:0] v_re;
    logic signed [VW-1:0] v_im;
    logic [PW-1:0]        den;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [MW-1:0]        rem_re;
    logic [MW-1:0]        rem_im;
    logic [QW-1:0]        q_re;
    logic [QW-1:0]        q_im;
  } dstage_t;

  logic          en;
  logic [NS-1:0] vld;
  prod_t         s1_next, s1;
  dstage_t       dv [QW+1];
  dstage_t       dv0_next;
  dstage_t       dvn [QW];
  rsp_t          rsp_next;

  // whole pipe advances unless the output beat is stuck
  assign en        = !vld[NS-1] || rsp_ready;
  assign item_take = en && item_valid;
  assign rsp_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], item_valid};
    end
  end

  // products and narrow sums
  always_comb begin
    logic signed [W+1:0]  ar, ai, br, bi;
    logic signed [PW-1:0] arw, aiw, brw, biw;
    ar  = {{2{item.a_re[W-1]}}, item.a_re};
    ai  = {{2{item.a_im[W-1]}}, item.a_im};
    br  = {{2{item.b_re[W-1]}}, item.b_re};
    bi  = {{2{item.b_im[W-1]}}, item.b_im};
    arw = {{(PW-W){item.a_re[W-1]}}, item.a_re};
    aiw = {{(PW-W){item.a_im[W-1]}}, item.a_im};
    brw = {{(PW-W){item.b_re[W-1]}}, item.b_re};
    biw = {{(PW-W){item.b_im[W-1]}}, item.b_im};
    s1_next.op   = item.op;
    s1_next.p_rr = arw * brw;
    s1_next.p_ii = aiw * biw;
    s1_next.p_ri = arw * biw;
    s1_next.p_ir = aiw * brw;
    s1_next.d_r  = $unsigned(brw * brw);
    s1_next.d_i  = $unsigned(biw * biw);
    case (item.op)
      OP_ADD: begin
        s1_next.s_re = ar + br;
        s1_next.s_im = ai + bi;
      end
      OP_SUB: begin
        s1_next.s_re = ar - br;
        s1_next.s_im = ai - bi;
      end
      OP_CONJ: begin
        s1_next.s_re = ar;
        s1_next.s_im = -ai;
      end
      default: begin
        s1_next.s_re = '0;
        s1_next.s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  // sums of products, sign/magnitude of numerators, divisor
  always_comb begin
    logic signed [PW:0] mre, mim, nre, nim;
    logic [PW:0]        mg_re, mg_im;
    mre = $signed({s1.p_rr[PW-1], s1.p_rr}) - $signed({s1.p_ii[PW-1], s1.p_ii});
    mim = $signed({s1.p_ri[PW-1], s1.p_ri}) + $signed({s1.p_ir[PW-1], s1.p_ir});
    nre = $signed({s1.p_rr[PW-1], s1.p_rr}) + $signed({s1.p_ii[PW-1], s1.p_ii});
    nim = $signed({s1.p_ir[PW-1], s1.p_ir}) - $signed({s1.p_ri[PW-1], s1.p_ri});
    mg_re = nre[PW] ? $unsigned(-nre) : $unsigned(nre);
    mg_im = nim[PW] ? $unsigned(-nim) : $unsigned(nim);
    dv0_next        = '0;
    dv0_next.op     = s1.op;
    dv0_next.den    = s1.d_r + s1.d_i;
    dv0_next.dz     = (s1.op == OP_DIV) && (dv0_next.den == '0);
    dv0_next.neg_re = nre[PW];
    dv0_next.neg_im = nim[PW];
    dv0_next.rem_re = {mg_re[PW-1:0], {FRAC_BITS{1'b0}}};
    dv0_next.rem_im = {mg_im[PW-1:0], {FRAC_BITS{1'b0}}};
    case (s1.op)
      OP_ADD, OP_SUB, OP_CONJ: begin
        dv0_next.v_re = {{(VW-W-2){s1.s_re[W+1]}}, s1.s_re};
        dv0_next.v_im = {{(VW-W-2){s1.s_im[W+1]}}, s1.s_im};
      end
      OP_MUL: begin
        // arithmetic shift rounds toward minus infinity
        dv0_next.v_re = VW'(mre >>> FRAC_BITS);
        dv0_next.v_im = VW'(mim >>> FRAC_BITS);
      end
      default: begin
        dv0_next.v_re = '0;
        dv0_next.v_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    always_comb begin
      logic [CW-1:0] dsh, rr, ri;
      dvn[j] = dv[j];
      dsh = CW'(dv[j].den) << K;
      rr  = CW'(dv[j].rem_re);
      ri  = CW'(dv[j].rem_im);
      if (rr >= dsh) begin
        dvn[j].rem_re  = MW'(rr - dsh);
        dvn[j].q_re[K] = 1'b1;
      end
      if (ri >= dsh) begin
        dvn[j].rem_im  = MW'(ri - dsh);
        dvn[j].q_im[K] = 1'b1;
      end
      if (j == 0) begin
        // quotient needs more bits than kept: result saturates
        dvn[j].big_re = rr >= (CW'(dv[j].den) << QW);
        dvn[j].big_im = ri >= (CW'(dv[j].den) << QW);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dvn[j];
      end
    end
  end

  // final value select and saturation
  always_comb begin
    logic signed [VW-1:0] smax, smin, vre, vim, qre, qim;
    logic                 sat_re, sat_im;
    smax = $signed({{(VW-W+1){1'b0}}, {(W-1){1'b1}}});
    smin = ~smax;
    qre  = dv[QW].big_re ? $signed(VW'(1) << QW) : $signed(VW'(dv[QW].q_re));
    qim  = dv[QW].big_im ? $signed(VW'(1) << QW) : $signed(VW'(dv[QW].q_im));
    if (dv[QW].op == OP_DIV) begin
      vre = dv[QW].dz ? '0 : (dv[QW].neg_re ? -qre : qre);
      vim = dv[QW].dz ? '0 : (dv[QW].neg_im ? -qim : qim);
    end else begin
      vre = dv[QW].v_re;
      vim = dv[QW].v_im;
    end
    sat_re = (vre > smax) || (vre < smin);
    sat_im = (vim > smax) || (vim < smin);
    rsp_next.res_re = sat_re ? (vre[VW-1] ? smin[W-1:0] : smax[W-1:0]) : vre[W-1:0];
    rsp_next.res_im = sat_im ? (vim[VW-1] ? smin[W-1:0] : smax[W-1:0]) : vim[W-1:0];
    rsp_next.overflow    = sat_re || sat_im;
    rsp_next.div_by_zero = dv[QW].dz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide and conjugate on
// signed Q8.8 complex operands, one result beat per request beat, in order.
// Sustained rate is one beat per clock while rsp_ready stays high; the pipe has
// a product register, a sum register, one pipelined divider stage per quotient
// bit and an output register, and beats may also wait in the request queue. Every
// command runs through the same pipe, so results never reorder. The front
// decodes the command and writes into a QUEUE_DEPTH-entry queue; the back
// pipe pulls from it and freezes only while the output beat waits for
// rsp_ready. Out-of-range results saturate with overflow set; divide by a
// zero B gives zero with div_by_zero set. Unknown commands return all zero.
module complex_arithmetic_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cau_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cau_pkg::rsp_t rsp
);
  import cau_pkg::*;

  item_t item_in;   // decoded request, into the queue
  item_t item_out;  // head of queue, into the back pipe
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;

  // request side only sees queue space
  assign req_ready = !q_full;

  cau_front u_front (
    .req  (req),
    .item (item_in)
  );

  cau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req_valid),
    .wdata    (item_in),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (item_out)
  );

  // back pipe: multipliers, divider stages and output register
  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_nonempty),
    .item       (item_out),
    .item_take  (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/cau_checker.sv =====
module cau_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input cau_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cau_pkg::rsp_t rsp
);
  import cau_pkg::*;

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request beat dropped or changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not idle after reset");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_by_zero |-> rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
    else $error("divide by zero result not clean");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result beat without request");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ===== tb/cau_checker.sv =====
`timescale 1ns / 1ps

module cau_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  cau_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  cau_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  import cau_pkg::*;

  localparam longint MAXPOS = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint MINNEG = -(64'sd1 <<< (DATA_WIDTH - 1));

  rsp_t expected_q[$];

  function automatic logic [DATA_WIDTH-1:0] clamp(input longint v, inout logic ovf);
    if (v > MAXPOS) begin
      ovf = 1'b1;
      return MAXPOS[DATA_WIDTH-1:0];
    end
    if (v < MINNEG) begin
      ovf = 1'b1;
      return MINNEG[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // num * 2^FRAC / den, truncated toward zero; magnitude capped so huge values saturate
  function automatic longint scaled_quot(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    q = ((q <<< FRAC_BITS) + (((mag % den) <<< FRAC_BITS) / den));
    return (num < 0) ? -q : q;
  endfunction

  function automatic rsp_t complex_result(input req_t r);
    rsp_t o;
    longint ar, ai, br, bi, den;
    logic ovf;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    ovf = 1'b0;
    o = '0;
    case (r.cmd)
      CMD_ADD: begin
        o.res_re = clamp(ar + br, ovf);
        o.res_im = clamp(ai + bi, ovf);
      end
      CMD_SUB: begin
        o.res_re = clamp(ar - br, ovf);
        o.res_im = clamp(ai - bi, ovf);
      end
      CMD_MUL: begin
        // arithmetic shift = floor
        o.res_re = clamp((ar * br - ai * bi) >>> FRAC_BITS, ovf);
        o.res_im = clamp((ar * bi + ai * br) >>> FRAC_BITS, ovf);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) o.div_by_zero = 1'b1;
        else begin
          o.res_re = clamp(scaled_quot(ar * br + ai * bi, den), ovf);
          o.res_im = clamp(scaled_quot(ai * br - ar * bi, den), ovf);
        end
      end
      CMD_CONJ: begin
        o.res_re = clamp(ar, ovf);
        o.res_im = clamp(-ai, ovf);
      end
      default: ;
    endcase
    o.overflow = ovf;
    return o;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH t=%0t: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_q.push_back(complex_result(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) report("result beat with nothing expected");
        else begin
          want = expected_q.pop_front();
          if (rsp.res_re !== want.res_re)
            report($sformatf("res_re got %0d want %0d", rsp.res_re, want.res_re));
          if (rsp.res_im !== want.res_im)
            report($sformatf("res_im got %0d want %0d", rsp.res_im, want.res_im));
          if (rsp.overflow !== want.overflow)
            report($sformatf("overflow got %b want %b", rsp.overflow, want.overflow));
          if (rsp.div_by_zero !== want.div_by_zero)
            report($sformatf("div_by_zero got %b want %b", rsp.div_by_zero,
                             want.div_by_zero));
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  localparam int RANDOM_BEATS = 600;
  localparam int WATCHDOG     = 5000;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  req_t req;
  rsp_t rsp;
  int   fail_count, pending;
  int   idle_cycles;
  bit   quiet_tail;   // no idling near the end
  bit   hold_rsp;     // long receiver hold-off

  complex_arithmetic_unit uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  cau_scoreboard checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready idles in random bursts, or holds off on request.
  initial begin
    int n;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        for (int i = 0; i < 60; i++) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        rsp_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one beat; valid stays up until accepted. Caller lowers valid.
  task automatic send_beat(input logic [2:0] cmd, input logic [15:0] ar,
                           input logic [15:0] ai, input logic [15:0] br,
                           input logic [15:0] bi);
    req_valid <= 1'b1;
    req <= '{cmd: cmd, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Operand with bias toward extremes and small values.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] cmd;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    hold_rsp = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every command, divide by zero, conj of min, unknown.
    send_beat(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_beat(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
    send_beat(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'hffff);
    send_beat(CMD_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    send_beat(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(CMD_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_beat(CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
    send_beat(CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_beat(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_beat(CMD_DIV, 16'h0100, 16'h0200, 16'h0100, 16'hff00);
    send_beat(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(CMD_DIV, 16'hffff, 16'h0003, 16'h7fff, 16'h0007);
    send_beat(CMD_CONJ, 16'h1234, 16'h8000, 16'hffff, 16'hffff);
    send_beat(CMD_CONJ, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_beat(3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_beat(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(3'd7, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
    req_valid <= 1'b0;

    // Random phase, with one long receiver hold-off and one full drain.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 150) hold_rsp = 1'b1;
      if (i == 300) begin
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i == 500) quiet_tail = 1'b1;
      maybe_gap();
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      send_beat(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
